>>> rtl/otpct_pkg.sv
// ----------------------------------------------------------------------------
// otpct_pkg
// Shared types and codes for the ordered two-phase completion table.
// ----------------------------------------------------------------------------
package otpct_pkg;

  localparam int unsigned VersionWidth = 31;
  localparam int unsigned KindWidth    = 3;
  localparam int unsigned StatusWidth  = 2;

  typedef enum logic [KindWidth-1:0] {
    KIND_ADD_DATA    = 3'd0,
    KIND_ADD_META    = 3'd1,
    KIND_FINISH_META = 3'd2,
    KIND_FINISH_DATA = 3'd3,
    KIND_QUERY       = 3'd4
  } kind_e;

  typedef enum logic [StatusWidth-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_MISSING = 2'd2
  } status_e;

  // sequencer: scan finds the slot, decide answers, shift moves entries
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT
  } state_e;

  // one table entry as stored in the ram word
  typedef struct packed {
    logic                    meta_done;
    logic                    data_done;
    logic [VersionWidth-1:0] version;
  } entry_t;

endpackage

>>> rtl/ordered_two_phase_completion_table_core.sv
// ----------------------------------------------------------------------------
// ordered_two_phase_completion_table_core
// Version-ordered table of pending alters kept in one ram, with per-item
// lookup, sorted insert and removal done by a sequencer over the ram.
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | input     | in_valid_i, in_stall_o, kind_i, version_i, has_mutation_i
// out     | output    | out_valid_o, out_stall_i, head_*_o, can_run_*_o, status_o
//
// the scan reads the entries one a cycle, stopping at the first version not
// below the item or at the end of the table (none are read on an empty table);
// the decide state then answers and makes any in-place edit, and an insert
// or removal moves the later entries in the shift state. reset clears the
// entry count and the control registers, not the ram contents.
// the input stalls while an item is in work or its result is held off.
// ----------------------------------------------------------------------------
module ordered_two_phase_completion_table_core
  import otpct_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [KindWidth-1:0]    kind_i,
  input  logic [VersionWidth-1:0] version_i,
  input  logic                    has_mutation_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    head_valid_o,
  output logic [VersionWidth-1:0] head_version_o,
  output logic                    can_run_data_o,
  output logic                    can_run_meta_o,
  output logic [StatusWidth-1:0]  status_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned EntW = $bits(entry_t);
  localparam logic [CntW-1:0] Full = CntW'(TABLE_ENTRIES);

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] ptr_q, ptr_d;      // next scan read address
  logic [CntW-1:0] pos_q, pos_d;      // first slot not below the item
  logic [CntW-1:0] left_q, left_d;    // shift moves still to issue
  logic [IdxW-1:0] src_q, src_d;      // next shift read address
  logic [IdxW-1:0] dst_q, dst_d;      // write address of the read in flight
  logic            rd_pend_q, rd_pend_d;
  logic            ins_q, ins_d;      // shift direction: 1 insert, 0 remove
  kind_e           kind_q, kind_d;
  logic [VersionWidth-1:0] ver_q, ver_d;
  logic            hm_q, hm_d;
  logic [VersionWidth-1:0] head_q, head_d;
  entry_t          hit_q, hit_d;      // entry found at pos
  logic            found_q, found_d;
  entry_t          new_q, new_d;      // entry to write at pos after shift

  logic            o_valid_q, o_valid_d;
  logic            o_hv_q, o_rd_q, o_rm_q;
  logic [VersionWidth-1:0] o_head_q;
  logic [StatusWidth-1:0]  o_st_q;

  logic            empty, below_head;
  logic            fin_rd, fin_rm;
  status_e         fin_st;
  logic            act_write, act_ins, act_rem;
  entry_t          act_entry;
  logic            scan_hit, scan_done, shift_done;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t          wdata, rdata;
  logic            accept;

  otpct_ram #(.Width(EntW), .Depth(TABLE_ENTRIES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE) || (o_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // scan stops at the first entry not below the item, or at the end
  assign scan_hit   = rd_pend_q && (rdata.version >= ver_q);
  assign scan_done  = rd_pend_q ? (scan_hit || (ptr_q >= count_q)) : (count_q == '0);
  assign shift_done = (left_q == '0) && !rd_pend_q;

  // decision of the item once the scan has stopped
  assign empty      = (count_q == '0);
  assign below_head = empty || (ver_q < head_q);
  always_comb begin
    fin_rd    = 1'b0;
    fin_st    = STATUS_OK;
    act_write = 1'b0;
    act_ins   = 1'b0;
    act_rem   = 1'b0;
    act_entry = hit_q;
    fin_rm    = empty || (ver_q == head_q);
    if (below_head) fin_rd = 1'b1;
    else if (found_q) fin_rd = hit_q.meta_done;
    case (kind_q)
      KIND_ADD_DATA: begin
        if (found_q) begin
          act_write = 1'b1;
          act_entry.data_done = 1'b0;
        end else if (count_q >= Full) begin
          fin_st = STATUS_FULL;
        end else begin
          act_ins = 1'b1;
          act_entry.version   = ver_q;
          act_entry.meta_done = 1'b1;
          act_entry.data_done = 1'b0;
        end
      end
      KIND_ADD_META: begin
        if (found_q) begin
          act_write = 1'b1;
          act_entry.meta_done = 1'b0;
        end else if (count_q >= Full) begin
          fin_st = STATUS_FULL;
        end else begin
          act_ins = 1'b1;
          act_entry.version   = ver_q;
          act_entry.meta_done = 1'b0;
          act_entry.data_done = !hm_q;
        end
      end
      KIND_FINISH_META: begin
        if (empty || (ver_q != head_q)) begin
          fin_st = STATUS_MISSING;
        end else if (hit_q.data_done) begin
          act_rem = 1'b1;
        end else begin
          act_write = 1'b1;
          act_entry.meta_done = 1'b1;
        end
      end
      KIND_FINISH_DATA: begin
        if (!below_head) begin
          if (!found_q) begin
            fin_st = STATUS_MISSING;
          end else if (hit_q.meta_done) begin
            act_rem = 1'b1;
          end else begin
            act_write = 1'b1;
            act_entry.data_done = 1'b1;
          end
        end
      end
      default: begin
        if (!below_head && !found_q) fin_st = STATUS_MISSING;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_SCAN;
      ST_SCAN:   if (scan_done) state_d = ST_DECIDE;
      ST_DECIDE: state_d = (act_ins || act_rem) ? ST_SHIFT : ST_IDLE;
      ST_SHIFT:  if (shift_done) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    ptr_d = ptr_q; pos_d = pos_q; left_d = left_q; src_d = src_q; dst_d = dst_q;
    rd_pend_d = 1'b0; ins_d = ins_q; kind_d = kind_q; ver_d = ver_q; hm_d = hm_q;
    head_d = head_q; hit_d = hit_q; found_d = found_q; new_d = new_q;
    count_d = count_q;
    o_valid_d = o_valid_q && out_stall_i;
    we = 1'b0; waddr = dst_q; wdata = rdata; raddr = src_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          kind_d  = (kind_i > KIND_QUERY) ? KIND_QUERY : kind_e'(kind_i);
          ver_d   = version_i;
          hm_d    = has_mutation_i;
          ptr_d   = '0;
          head_d  = '0;
          found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        raddr = ptr_q[IdxW-1:0];
        if (rd_pend_q && (ptr_q == CntW'(1))) head_d = rdata.version;
        if (scan_done) begin
          pos_d   = scan_hit ? (ptr_q - 1'b1) : ptr_q;
          found_d = scan_hit && (rdata.version == ver_q);
          hit_d   = rdata;
        end else begin
          ptr_d     = ptr_q + 1'b1;
          rd_pend_d = 1'b1;
        end
      end
      ST_DECIDE: begin
        // in-place edit now, or set up the shift for insert or removal
        new_d     = act_entry;
        ins_d     = act_ins;
        o_valid_d = 1'b1;
        if (act_write) begin
          we = 1'b1; waddr = pos_q[IdxW-1:0]; wdata = act_entry;
        end
        if (act_ins) begin
          count_d = count_q + 1'b1;
          left_d  = count_q - pos_q;
          src_d   = IdxW'(count_q - 1'b1);
        end
        if (act_rem) begin
          count_d = count_q - 1'b1;
          left_d  = count_q - pos_q - 1'b1;
          src_d   = IdxW'(pos_q + 1'b1);
        end
      end
      ST_SHIFT: begin
        // one entry moves per cycle; each read is written back in the cycle after it is issued
        if (rd_pend_q) begin
          we = 1'b1; waddr = dst_q; wdata = rdata;
        end
        if (left_q != '0) begin
          raddr     = src_q;
          rd_pend_d = 1'b1;
          dst_d     = ins_q ? (src_q + 1'b1) : (src_q - 1'b1);
          src_d     = ins_q ? (src_q - 1'b1) : (src_q + 1'b1);
          left_d    = left_q - 1'b1;
        end else if (!rd_pend_q && ins_q) begin
          we = 1'b1; waddr = pos_q[IdxW-1:0]; wdata = new_q;
        end
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      ptr_q     <= '0;
      pos_q     <= '0;
      left_q    <= '0;
      src_q     <= '0;
      dst_q     <= '0;
      rd_pend_q <= 1'b0;
      ins_q     <= 1'b0;
      kind_q    <= KIND_QUERY;
      ver_q     <= '0;
      hm_q      <= 1'b0;
      head_q    <= '0;
      hit_q     <= '0;
      found_q   <= 1'b0;
      new_q     <= '0;
      o_valid_q <= 1'b0;
      o_hv_q    <= 1'b0;
      o_head_q  <= '0;
      o_rd_q    <= 1'b0;
      o_rm_q    <= 1'b0;
      o_st_q    <= STATUS_OK;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      pos_q     <= pos_d;
      left_q    <= left_d;
      src_q     <= src_d;
      dst_q     <= dst_d;
      rd_pend_q <= rd_pend_d;
      ins_q     <= ins_d;
      kind_q    <= kind_d;
      ver_q     <= ver_d;
      hm_q      <= hm_d;
      head_q    <= head_d;
      hit_q     <= hit_d;
      found_q   <= found_d;
      new_q     <= new_d;
      o_valid_q <= o_valid_d;
      if (state_q == ST_DECIDE) begin
        o_hv_q   <= !empty;
        o_head_q <= head_q;
        o_rd_q   <= fin_rd;
        o_rm_q   <= fin_rm;
        o_st_q   <= fin_st;
      end
    end
  end

  assign out_valid_o    = o_valid_q;
  assign head_valid_o   = o_hv_q;
  assign head_version_o = o_head_q;
  assign can_run_data_o = o_rd_q;
  assign can_run_meta_o = o_rm_q;
  assign status_o       = o_st_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full) else $error("entry count above table size");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("input open while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(head_version_o)))
    else $error("result lost under stall");

endmodule

>>> rtl/otpct_ram.sv
// ----------------------------------------------------------------------------
// otpct_ram
// Generic single-port-write, single-port-read ram with registered read.
// ----------------------------------------------------------------------------
module otpct_ram #(
  parameter int unsigned Width = 33,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> tb/ordered_two_phase_completion_table_core_tb.sv
// ----------------------------------------------------------------------------
// ordered_two_phase_completion_table_core_tb
// Self-checking bench for the completion table: a directed opening, then
// random sequences of alters around moving version bases, with periodic
// clean-up sequences, bursty input, a patterned output stall and one long
// output hold. Every answer is checked against a local model of the table.
// ----------------------------------------------------------------------------
module ordered_two_phase_completion_table_core_tb;
  import otpct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Entries = 16;
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned LongHold = 400;

  typedef struct packed {
    logic [KindWidth-1:0]    kind;
    logic [VersionWidth-1:0] version;
    logic                    has_mutation;
  } alter_item_t;

  typedef struct packed {
    logic                    head_valid;
    logic [VersionWidth-1:0] head_version;
    logic                    can_run_data;
    logic                    can_run_meta;
    logic [StatusWidth-1:0]  status;
  } table_answer_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [KindWidth-1:0]    kind_i = '0;
  logic [VersionWidth-1:0] version_i = '0;
  logic                    has_mutation_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    head_valid_o;
  logic [VersionWidth-1:0] head_version_o;
  logic                    can_run_data_o;
  logic                    can_run_meta_o;
  logic [StatusWidth-1:0]  status_o;

  ordered_two_phase_completion_table_core #(
    .TABLE_ENTRIES(Entries)
  ) i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .version_i, .has_mutation_i,
    .out_valid_o, .out_stall_i, .head_valid_o, .head_version_o, .can_run_data_o,
    .can_run_meta_o, .status_o
  );

  always #10 clk_i = ~clk_i;

  // local copy of the table
  logic [VersionWidth-1:0] tbl_version [Entries];
  logic                    tbl_meta_done [Entries];
  logic                    tbl_data_done [Entries];
  int unsigned             tbl_count = 0;

  alter_item_t   alters_to_send [$];
  table_answer_t pending_answers [$];
  int unsigned   mismatches = 0;
  int unsigned   accepted_alters = 0;
  int unsigned   checked_answers = 0;
  int unsigned   status_seen [4] = '{0, 0, 0, 0};
  bit            took_alter = 1'b0;

  // remove entry at idx, closing the gap
  function automatic void drop_entry(int unsigned idx);
    for (int unsigned i = idx; i + 1 < tbl_count; i++) begin
      tbl_version[i] = tbl_version[i+1];
      tbl_meta_done[i] = tbl_meta_done[i+1];
      tbl_data_done[i] = tbl_data_done[i+1];
    end
    tbl_count--;
  endfunction

  // sorted insert, returns full status when no room
  function automatic status_e place_entry(logic [VersionWidth-1:0] v, logic md, logic dd);
    int unsigned pos;
    pos = 0;
    if (tbl_count >= Entries) return STATUS_FULL;
    while (pos < tbl_count && tbl_version[pos] < v) pos++;
    for (int unsigned i = tbl_count; i > pos; i--) begin
      tbl_version[i] = tbl_version[i-1];
      tbl_meta_done[i] = tbl_meta_done[i-1];
      tbl_data_done[i] = tbl_data_done[i-1];
    end
    tbl_version[pos] = v;
    tbl_meta_done[pos] = md;
    tbl_data_done[pos] = dd;
    tbl_count++;
    return STATUS_OK;
  endfunction

  // answer judged on the table before the update, then apply the update
  function automatic table_answer_t apply_alter_item(alter_item_t it);
    table_answer_t ans;
    logic empty, found, miss;
    logic [VersionWidth-1:0] head;
    int unsigned slot;
    status_e st;
    empty = (tbl_count == 0);
    head = empty ? '0 : tbl_version[0];
    slot = tbl_count;
    for (int unsigned i = 0; i < tbl_count; i++)
      if (tbl_version[i] == it.version && slot == tbl_count) slot = i;
    found = (slot < tbl_count);
    miss = 1'b0;
    st = STATUS_OK;
    if (empty || it.version < head) ans.can_run_data = 1'b1;
    else if (found) ans.can_run_data = tbl_meta_done[slot];
    else begin
      ans.can_run_data = 1'b0;
      miss = 1'b1;
    end
    ans.can_run_meta = empty || (it.version == head);
    ans.head_valid = !empty;
    ans.head_version = head;
    case (it.kind)
      KIND_ADD_DATA: begin
        if (found) tbl_data_done[slot] = 1'b0;
        else st = place_entry(it.version, 1'b1, 1'b0);
      end
      KIND_ADD_META: begin
        if (found) tbl_meta_done[slot] = 1'b0;
        else st = place_entry(it.version, 1'b0, !it.has_mutation);
      end
      KIND_FINISH_META: begin
        if (empty || it.version != head) st = STATUS_MISSING;
        else if (tbl_data_done[0]) drop_entry(0);
        else tbl_meta_done[0] = 1'b1;
      end
      KIND_FINISH_DATA: begin
        if (!empty && it.version >= head) begin
          if (!found) st = STATUS_MISSING;
          else if (tbl_meta_done[slot]) drop_entry(slot);
          else tbl_data_done[slot] = 1'b1;
        end
      end
      default: if (miss) st = STATUS_MISSING;
    endcase
    ans.status = st;
    return ans;
  endfunction

  // driver: bursts of random length with random gaps
  int unsigned burst_left = 4;
  int unsigned gap_left = 0;
  always @(negedge clk_i) begin
    alter_item_t nxt;
    logic        nxt_valid;
    nxt_valid = in_valid_i;
    nxt = {kind_i, version_i, has_mutation_i};
    if (!in_valid_i || took_alter) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) gap_left--;
      else if (alters_to_send.size() > 0 && rst_ni) begin
        nxt = alters_to_send.pop_front();
        nxt_valid = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          // some bursts run back to back
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_valid_i <= nxt_valid;
    {kind_i, version_i, has_mutation_i} <= nxt;
  end

  // receiver stall pattern, plus one long hold once the run is under way
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned stall_mode = 0;
  always @(negedge clk_i) begin
    logic stall;
    if (!hold_done && accepted_alters >= 300) begin
      hold_done = 1'b1;
      hold_left = LongHold;
    end
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      stall = 1'b1;
    end else begin
      case (stall_mode)
        0: stall = 1'b0;
        1: stall = ($urandom_range(0, 3) == 0);
        2: stall = ($urandom_range(0, 1) == 0);
        default: stall = ($urandom_range(0, 3) != 0);
      endcase
    end
    out_stall_i <= stall;
  end

  // monitor: check answers, then predict for the accepted transaction
  always @(posedge clk_i) begin
    table_answer_t got, want;
    took_alter <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {head_valid_o, head_version_o, can_run_data_o, can_run_meta_o, status_o};
      checked_answers++;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected answer %p", got);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("answer mismatch: expected %p got %p", want, got);
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      want = apply_alter_item({kind_i, version_i, has_mutation_i});
      pending_answers.push_back(want);
      status_seen[want.status]++;
      accepted_alters++;
    end
  end

  // watchdog on cycles with no transaction
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_alter(kind_e k, logic [VersionWidth-1:0] v, logic hm);
    alter_item_t it;
    it.kind = k;
    it.version = v;
    it.has_mutation = hm;
    alters_to_send.push_back(it);
  endtask

  task automatic wait_drained();
    while (alters_to_send.size() > 0 || in_valid_i || pending_answers.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic [VersionWidth-1:0] base;
    alter_item_t it;
    int unsigned sent, r;
    bit overfilled;
    overfilled = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed opening: empty table, absent and present entries, below head
    push_alter(KIND_QUERY, 31'd5, 1'b0);
    push_alter(KIND_FINISH_META, 31'd5, 1'b0);
    push_alter(KIND_FINISH_DATA, 31'd5, 1'b0);
    push_alter(KIND_ADD_META, 31'd10, 1'b1);
    push_alter(KIND_ADD_DATA, 31'd10, 1'b0);
    push_alter(KIND_ADD_DATA, 31'd20, 1'b0);
    push_alter(KIND_QUERY, 31'd15, 1'b0);
    push_alter(KIND_QUERY, 31'd3, 1'b0);
    push_alter(KIND_FINISH_DATA, 31'd3, 1'b0);
    push_alter(KIND_FINISH_DATA, 31'd15, 1'b0);
    push_alter(KIND_FINISH_META, 31'd20, 1'b0);
    push_alter(KIND_FINISH_DATA, 31'd10, 1'b0);
    push_alter(KIND_FINISH_META, 31'd10, 1'b0);
    push_alter(KIND_ADD_META, 31'h7fff_ffff, 1'b0);
    push_alter(KIND_ADD_META, 31'd0, 1'b1);
    it = '{kind: 3'd7, version: 31'd0, has_mutation: 1'b1};
    alters_to_send.push_back(it);
    push_alter(KIND_FINISH_META, 31'd0, 1'b0);
    push_alter(KIND_FINISH_DATA, 31'd20, 1'b0);
    push_alter(KIND_FINISH_DATA, 31'd0, 1'b0);
    push_alter(KIND_FINISH_META, 31'h7fff_ffff, 1'b0);
    // sender holds off until every answer is in
    wait_drained();

    // random part in segments, each followed by a clean-up of what is left
    sent = 0;
    base = VersionWidth'($urandom()) & 31'h7fff_fff0;
    while (sent < 600) begin
      if ($urandom_range(0, 3) == 0) base = VersionWidth'($urandom()) & 31'h7fff_fff0;
      if (!overfilled && sent >= 200) begin
        // overfill the table with distinct versions
        overfilled = 1'b1;
        for (int unsigned i = 0; i < Entries + 3; i++)
          push_alter(($urandom_range(0, 1) == 0) ? KIND_ADD_DATA : KIND_ADD_META,
                     VersionWidth'(base + i), 1'($urandom_range(0, 1)));
        sent += Entries + 3;
      end
      for (int unsigned i = 0; i < 40; i++) begin
        r = $urandom_range(0, 99);
        it.version = VersionWidth'(base + $urandom_range(0, 9));
        it.has_mutation = 1'($urandom_range(0, 1));
        if (r < 8) begin
          it.kind = KindWidth'($urandom_range(0, 7));
          it.version = VersionWidth'($urandom());
        end else if (r < 25) it.kind = KIND_ADD_DATA;
        else if (r < 45) it.kind = KIND_ADD_META;
        else if (r < 65) it.kind = KIND_FINISH_META;
        else if (r < 85) it.kind = KIND_FINISH_DATA;
        else it.kind = KindWidth'($urandom_range(4, 7));
        alters_to_send.push_back(it);
      end
      sent += 40;
      wait_drained();
      for (int unsigned i = 0; i < tbl_count; i++) begin
        push_alter(KIND_FINISH_META, tbl_version[i], 1'b0);
        push_alter(KIND_FINISH_DATA, tbl_version[i], 1'b0);
      end
      sent += 2 * tbl_count;
      wait_drained();
    end

    repeat (100) @(posedge clk_i);
    $display("covered %0d alters, %0d answers checked", accepted_alters, checked_answers);
    $display("status ok %0d, full %0d, missing %0d, long output hold %0d cycles",
             status_seen[STATUS_OK], status_seen[STATUS_FULL],
             status_seen[STATUS_MISSING], LongHold);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d answers outstanding", mismatches,
               pending_answers.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/otpct_pkg.sv
rtl/otpct_ram.sv
rtl/ordered_two_phase_completion_table_core.sv
tb/ordered_two_phase_completion_table_core_tb.sv
